// File: design/imm_pkg.sv
// Shared constants, codes and types of the integer matrix multiply unit.
package imm_pkg;

  // Matrix shape: A is ROWS_A x INNER_DIM, B is INNER_DIM x COLS_B
  localparam int ROWS_A    = 8;
  localparam int INNER_DIM = 6;
  localparam int COLS_B    = 4;

  // Field widths of the channel words
  localparam int WORD_W    = 32;
  localparam int CMD_W     = 2;
  localparam int ROW_W     = 3;
  localparam int COL_W     = 3;
  localparam int OUT_ROW_W = 3;
  localparam int OUT_COL_W = 2;

  // Store depths and address widths
  localparam int A_DEPTH = ROWS_A * INNER_DIM;
  localparam int B_DEPTH = COLS_B * INNER_DIM;
  localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;

  // Sequencer counter widths
  localparam int R_W = (ROWS_A > 1)    ? $clog2(ROWS_A)    : 1;
  localparam int C_W = (COLS_B > 1)    ? $clog2(COLS_B)    : 1;
  localparam int K_W = (INNER_DIM > 1) ? $clog2(INNER_DIM) : 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_A = 2'd0,
    CMD_WRITE_B = 2'd1,
    CMD_COMPUTE = 2'd2
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_t;

  // Tag that travels with each multiply-accumulate step
  typedef struct packed {
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic                 first;
    logic                 dot_end;
    logic                 last;
  } tag_t;

  typedef struct packed {
    logic valid;
    tag_t tag;
  } issue_t;

  typedef struct packed {
    logic [OUT_ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0]     col;
    logic signed [WORD_W-1:0] value;
    logic                     last;
  } result_t;

endpackage

// File: design/imm_if.sv
// Valid/ready channel interfaces for the load/command input and the product output.
interface imm_in_if
  import imm_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [ROW_W-1:0]         row_index;
  logic [COL_W-1:0]         col_index;
  logic signed [WORD_W-1:0] element_value;

  modport source (output valid, command, row_index, col_index, element_value,
                  input ready);
  modport sink   (input valid, command, row_index, col_index, element_value,
                  output ready);
endinterface

interface imm_out_if
  import imm_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [OUT_ROW_W-1:0]     out_row;
  logic [OUT_COL_W-1:0]     out_col;
  logic signed [WORD_W-1:0] product_value;
  logic                     last;

  modport source (output valid, out_row, out_col, product_value, last,
                  input ready);
  modport sink   (input valid, out_row, out_col, product_value, last,
                  output ready);
endinterface

// File: design/imm_ram.sv
// Simple dual-port RAM: one write port, one registered read port with enable.
module imm_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, hold data while disabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/imm_seq.sv
// Compute sequencer: walks rows, columns and the inner index, driving store read addresses.
module imm_seq
  import imm_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            adv,
  output logic            ready,
  output logic [A_AW-1:0] a_addr,
  output logic [B_AW-1:0] b_addr,
  output issue_t          issue
);

  seq_state_t      state, state_next;
  logic [R_W-1:0]  r_cnt;
  logic [C_W-1:0]  c_cnt;
  logic [K_W-1:0]  k_cnt;
  logic [A_AW-1:0] a_base;
  logic [B_AW-1:0] b_base;
  logic            k_end, c_end, r_end;

  assign k_end = (k_cnt == K_W'(INNER_DIM - 1));
  assign c_end = (c_cnt == C_W'(COLS_B - 1));
  assign r_end = (r_cnt == R_W'(ROWS_A - 1));

  assign a_addr = A_AW'(a_base + A_AW'(k_cnt));
  assign b_addr = B_AW'(b_base + B_AW'(k_cnt));

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and issue
  always_comb begin
    state_next      = state;
    ready           = 1'b0;
    issue.valid     = 1'b0;
    issue.tag.row   = OUT_ROW_W'(r_cnt);
    issue.tag.col   = OUT_COL_W'(c_cnt);
    issue.tag.first = (k_cnt == '0);
    issue.tag.dot_end = k_end;
    issue.tag.last  = k_end && c_end && r_end;
    case (state)
      ST_IDLE: begin
        ready = 1'b1;
        if (start) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        issue.valid = adv;
        if (adv && k_end && c_end && r_end) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Advance the index counters on each issued step
  always_ff @(posedge clk) begin
    if (start) begin
      r_cnt  <= '0;
      c_cnt  <= '0;
      k_cnt  <= '0;
      a_base <= '0;
      b_base <= '0;
    end else if (issue.valid) begin
      if (k_end) begin
        k_cnt <= '0;
        if (c_end) begin
          c_cnt  <= '0;
          b_base <= '0;
          r_cnt  <= R_W'(r_cnt + 1'b1);
          a_base <= A_AW'(a_base + A_AW'(INNER_DIM));
        end else begin
          c_cnt  <= C_W'(c_cnt + 1'b1);
          b_base <= B_AW'(b_base + B_AW'(INNER_DIM));
        end
      end else begin
        k_cnt <= K_W'(k_cnt + 1'b1);
      end
    end
  end

  // Read addresses stay inside both stores
  assert property (@(posedge clk) disable iff (rst)
    issue.valid |-> (a_addr < A_DEPTH) && (b_addr < B_DEPTH))
    else $error("read address beyond store depth");

  // Issuing the final step returns the sequencer to idle
  assert property (@(posedge clk) disable iff (rst)
    issue.valid && issue.tag.last |=> state == ST_IDLE)
    else $error("sequencer did not stop after final step");

  // A stalled run holds its position
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) && !adv |=> $stable(k_cnt) && $stable(a_base) && $stable(b_base))
    else $error("sequencer moved during stall");

endmodule

// File: design/imm_mac.sv
// Multiply-accumulate pipeline with the output word register.
module imm_mac
  import imm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  issue_t            issue,
  input  logic [WORD_W-1:0] a_data,
  input  logic [WORD_W-1:0] b_data,
  input  logic              out_ready,
  output logic              adv,
  output logic              out_valid,
  output result_t           result
);

  logic              s1_valid, s2_valid;
  tag_t              s1_tag, s2_tag;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] sum;

  // Whole pipeline moves only when the output word can be replaced
  assign adv = !out_valid || out_ready;

  assign sum = s2_tag.first ? prod : WORD_W'(acc + prod);

  // Control of the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= issue.valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid && s2_tag.dot_end;
    end
  end

  // Multiply, accumulate, load the output word
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tag <= issue.tag;
      s2_tag <= s1_tag;
      prod   <= WORD_W'(a_data * b_data);
      if (s2_valid) begin
        acc <= sum;
      end
      if (s2_valid && s2_tag.dot_end) begin
        result.row   <= s2_tag.row;
        result.col   <= s2_tag.col;
        result.value <= $signed(sum);
        result.last  <= s2_tag.last;
      end
    end
  end

endmodule

// File: design/int_matrix_multiply_unit.sv
// Top level of the integer matrix multiply unit.
// Write words load one element of A (8x6) or B (6x4) each and are taken one per cycle
// while no compute runs; B is kept transposed, and writes outside the matrix or with the
// unused command are dropped. A compute word keeps the input not ready until all
// ROWS_A*COLS_B*INNER_DIM = 192 steps are issued, one multiply-accumulate per cycle unless
// the output stalls, set by the single read port of each store; the 32 products leave in
// row-major order with last on the final one. A stall on the output freezes the whole
// pipeline. The stores are not cleared at reset: read only what was written.
module int_matrix_multiply_unit
  import imm_pkg::*;
(
  input logic       clk,
  input logic       rst,
  imm_in_if.sink    in_ch,
  imm_out_if.source out_ch
);

  logic              accept;
  logic              a_we, b_we, start;
  logic [A_AW-1:0]   a_waddr, a_raddr;
  logic [B_AW-1:0]   b_waddr, b_raddr;
  logic [WORD_W-1:0] wdata, a_data, b_data;
  logic              adv, ready, out_valid;
  issue_t            issue;
  result_t           result;

  // Decode the input word
  assign accept  = in_ch.valid && in_ch.ready;
  assign a_we    = accept && (in_ch.command == CMD_WRITE_A) &&
                   (in_ch.row_index < ROWS_A) && (in_ch.col_index < INNER_DIM);
  assign b_we    = accept && (in_ch.command == CMD_WRITE_B) &&
                   (in_ch.row_index < INNER_DIM) && (in_ch.col_index < COLS_B);
  assign start   = accept && (in_ch.command == CMD_COMPUTE);
  assign a_waddr = A_AW'(int'(in_ch.row_index) * INNER_DIM + int'(in_ch.col_index));
  assign b_waddr = B_AW'(int'(in_ch.col_index) * INNER_DIM + int'(in_ch.row_index));
  assign wdata   = $unsigned(in_ch.element_value);
  assign in_ch.ready = ready;

  imm_ram #(.DEPTH(A_DEPTH), .WIDTH(WORD_W)) u_a_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (wdata),
    .re    (adv),
    .raddr (a_raddr),
    .rdata (a_data)
  );

  imm_ram #(.DEPTH(B_DEPTH), .WIDTH(WORD_W)) u_bt_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (wdata),
    .re    (adv),
    .raddr (b_raddr),
    .rdata (b_data)
  );

  imm_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .adv    (adv),
    .ready  (ready),
    .a_addr (a_raddr),
    .b_addr (b_raddr),
    .issue  (issue)
  );

  imm_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .a_data    (a_data),
    .b_data    (b_data),
    .out_ready (out_ch.ready),
    .adv       (adv),
    .out_valid (out_valid),
    .result    (result)
  );

  // Drive the output word
  assign out_ch.valid         = out_valid;
  assign out_ch.out_row       = result.row;
  assign out_ch.out_col       = result.col;
  assign out_ch.product_value = result.value;
  assign out_ch.last          = result.last;

endmodule

// File: test/tb_int_matrix_multiply_unit.sv
// Testbench of the integer matrix multiply unit: directed table, random words, product checks.
module tb_int_matrix_multiply_unit;
  import imm_pkg::*;

  localparam logic [CMD_W-1:0]  CMD_UNUSED    = 2'd3;
  localparam logic [WORD_W-1:0] INT_MIN       = 32'h8000_0000;
  localparam logic [WORD_W-1:0] INT_MAX       = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] ALL_ONES      = 32'hffff_ffff;
  localparam int                RANDOM_ITEMS  = 72;
  localparam int                SETTLE_CYCLES = 24;
  localparam int                DIR_N         = 22;

  typedef enum int {
    PH_FREE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH
  } idle_phase_t;

  // One row of the directed table; typed rows carry their expectation inline
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [WORD_W-1:0] val;
    logic              typed;
    logic [WORD_W-1:0] typed_val;
  } dir_row_t;

  logic clk;
  logic rst;

  imm_in_if  in_ch ();
  imm_out_if out_ch ();

  int_matrix_multiply_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copies of A and of transposed B
  logic [WORD_W-1:0] mat_a  [A_DEPTH];
  logic [WORD_W-1:0] mat_bt [B_DEPTH];

  result_t     expected_products [$];
  idle_phase_t idle_phase = PH_FREE;
  logic              word_typed     = 1'b0;
  logic [WORD_W-1:0] word_typed_val = '0;

  int fail_count       = 0;
  int products_checked = 0;
  int computes_taken   = 0;
  int writes_taken     = 0;
  int drops_taken      = 0;

  // Clock: period 8
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Update the shadow stores and queue the products of a compute word
  task automatic track_word(input logic [CMD_W-1:0] cmd, input logic [ROW_W-1:0] row,
                            input logic [COL_W-1:0] col, input logic [WORD_W-1:0] val);
    logic [WORD_W-1:0] acc;
    result_t           res;
    int                r;
    int                c;
    int                k;
    case (cmd)
      CMD_WRITE_A: begin
        if (int'(row) < ROWS_A && int'(col) < INNER_DIM) begin
          mat_a[int'(row) * INNER_DIM + int'(col)] = val;
          writes_taken++;
        end else begin
          drops_taken++;
        end
      end
      CMD_WRITE_B: begin
        if (int'(row) < INNER_DIM && int'(col) < COLS_B) begin
          mat_bt[int'(col) * INNER_DIM + int'(row)] = val;
          writes_taken++;
        end else begin
          drops_taken++;
        end
      end
      CMD_COMPUTE: begin
        computes_taken++;
        for (r = 0; r < ROWS_A; r++) begin
          for (c = 0; c < COLS_B; c++) begin
            acc = '0;
            for (k = 0; k < INNER_DIM; k++) begin
              acc = acc + mat_a[r * INNER_DIM + k] * mat_bt[c * INNER_DIM + k];
            end
            res.row   = OUT_ROW_W'(r);
            res.col   = OUT_COL_W'(c);
            res.value = word_typed ? word_typed_val : acc;
            res.last  = (r == ROWS_A - 1) && (c == COLS_B - 1);
            expected_products.push_back(res);
          end
        end
      end
      default: begin
        drops_taken++;
      end
    endcase
  endtask

  // Check products first, then take the accepted input word
  always @(posedge clk) begin
    result_t want;
    if (rst === 1'b0) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_products.size() == 0) begin
          $error("unexpected product: row %0d col %0d value %0d last %0b", out_ch.out_row,
                 out_ch.out_col, out_ch.product_value, out_ch.last);
          fail_count++;
        end else begin
          want = expected_products.pop_front();
          products_checked++;
          if (out_ch.out_row !== want.row) begin
            $error("out_row: expected %0d, got %0d", want.row, out_ch.out_row);
            fail_count++;
          end
          if (out_ch.out_col !== want.col) begin
            $error("out_col: expected %0d, got %0d", want.col, out_ch.out_col);
            fail_count++;
          end
          if (out_ch.product_value !== want.value) begin
            $error("product_value: expected %0d, got %0d", want.value, out_ch.product_value);
            fail_count++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_ch.last);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        track_word(in_ch.command, in_ch.row_index, in_ch.col_index, in_ch.element_value);
      end
    end
  end

  // Receiver: stall according to the current phase
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      case (idle_phase)
        PH_RECV_STALL: out_ch.ready <= ($urandom_range(0, 99) >= 53);
        PH_BOTH:       out_ch.ready <= ($urandom_range(0, 99) >= 16);
        default:       out_ch.ready <= 1'b1;
      endcase
    end
  end

  function automatic bit sender_idles();
    case (idle_phase)
      PH_SEND_IDLE: return $urandom_range(0, 99) < 53;
      PH_BOTH:      return $urandom_range(0, 99) < 16;
      default:      return 1'b0;
    endcase
  endfunction

  // Drive one word from a falling edge, hold it until taken, return at a falling edge
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [ROW_W-1:0] row,
                           input logic [COL_W-1:0] col, input logic [WORD_W-1:0] val,
                           input logic typed, input logic [WORD_W-1:0] typed_val);
    while (sender_idles()) begin
      in_ch.valid         <= 1'b0;
      in_ch.command       <= CMD_W'($urandom);
      in_ch.row_index     <= ROW_W'($urandom);
      in_ch.col_index     <= COL_W'($urandom);
      in_ch.element_value <= $urandom;
      @(negedge clk);
    end
    word_typed          = typed;
    word_typed_val      = typed_val;
    in_ch.valid         <= 1'b1;
    in_ch.command       <= cmd;
    in_ch.row_index     <= row;
    in_ch.col_index     <= col;
    in_ch.element_value <= val;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Hold the input idle until every queued product has been seen
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_products.size() != 0) @(negedge clk);
  endtask

  // Main stimulus
  initial begin
    dir_row_t          dir_tab [DIR_N];
    logic [CMD_W-1:0]  cmd;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [WORD_W-1:0] val;
    int                kind;
    int                sel;
    int                counted;
    int                ph;
    int                i;
    int                j;

    rst                 = 1'b1;
    in_ch.valid         = 1'b0;
    in_ch.command       = '0;
    in_ch.row_index     = '0;
    in_ch.col_index     = '0;
    in_ch.element_value = '0;

    dir_tab = '{
      // compute on cleared stores: every product is zero
      '{CMD_COMPUTE, 3'd0, 3'd0, 32'd0, 1'b1, 32'd0},
      // extremes at the corners of A and B; writes give no product
      '{CMD_WRITE_A, 3'd0, 3'd0, INT_MIN, 1'b1, 32'd0},
      '{CMD_WRITE_A, 3'd7, 3'd5, INT_MAX, 1'b1, 32'd0},
      '{CMD_WRITE_A, 3'd0, 3'd5, ALL_ONES, 1'b1, 32'd0},
      '{CMD_WRITE_A, 3'd7, 3'd0, 32'd1, 1'b1, 32'd0},
      '{CMD_WRITE_B, 3'd0, 3'd0, INT_MIN, 1'b1, 32'd0},
      '{CMD_WRITE_B, 3'd5, 3'd3, INT_MAX, 1'b1, 32'd0},
      '{CMD_WRITE_B, 3'd5, 3'd0, ALL_ONES, 1'b1, 32'd0},
      '{CMD_WRITE_B, 3'd0, 3'd3, ALL_ONES, 1'b1, 32'd0},
      // out-of-range writes are dropped and must not disturb the stores
      '{CMD_WRITE_A, 3'd0, 3'd6, 32'hdead_beef, 1'b1, 32'd0},
      '{CMD_WRITE_A, 3'd7, 3'd7, ALL_ONES, 1'b1, 32'd0},
      '{CMD_WRITE_B, 3'd6, 3'd0, 32'h1234_5678, 1'b1, 32'd0},
      '{CMD_WRITE_B, 3'd7, 3'd7, ALL_ONES, 1'b1, 32'd0},
      '{CMD_WRITE_B, 3'd0, 3'd4, 32'hcafe_f00d, 1'b1, 32'd0},
      // unused command is dropped
      '{CMD_UNUSED, 3'd7, 3'd7, ALL_ONES, 1'b1, 32'd0},
      '{CMD_COMPUTE, 3'd7, 3'd7, ALL_ONES, 1'b0, 32'd0},
      '{CMD_WRITE_A, 3'd3, 3'd2, INT_MIN, 1'b1, 32'd0},
      '{CMD_WRITE_B, 3'd2, 3'd1, INT_MIN, 1'b1, 32'd0},
      '{CMD_COMPUTE, 3'd0, 3'd0, 32'd0, 1'b0, 32'd0},
      '{CMD_UNUSED, 3'd0, 3'd0, 32'd0, 1'b1, 32'd0},
      // back-to-back computes
      '{CMD_COMPUTE, 3'd5, 3'd2, 32'h5555_aaaa, 1'b0, 32'd0},
      '{CMD_COMPUTE, 3'd2, 3'd5, 32'haaaa_5555, 1'b0, 32'd0}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Clear every element so that no compute reads an unwritten entry
    for (i = 0; i < ROWS_A; i++) begin
      for (j = 0; j < INNER_DIM; j++) begin
        send_word(CMD_WRITE_A, ROW_W'(i), COL_W'(j), '0, 1'b1, '0);
      end
    end
    for (i = 0; i < INNER_DIM; i++) begin
      for (j = 0; j < COLS_B; j++) begin
        send_word(CMD_WRITE_B, ROW_W'(i), COL_W'(j), '0, 1'b1, '0);
      end
    end

    // Walk the directed table
    for (i = 0; i < DIR_N; i++) begin
      send_word(dir_tab[i].cmd, dir_tab[i].row, dir_tab[i].col, dir_tab[i].val,
                dir_tab[i].typed, dir_tab[i].typed_val);
    end
    wait_drained();

    // Random words, one quarter per idling phase, each ending with a compute
    counted = 0;
    for (ph = 0; ph < 4; ph++) begin
      idle_phase = idle_phase_t'(ph);
      while (counted < (ph + 1) * RANDOM_ITEMS / 4) begin
        kind = $urandom_range(0, 99);
        row  = ROW_W'($urandom);
        col  = COL_W'($urandom);
        if (kind < 8) begin
          cmd = CMD_COMPUTE;
        end else if (kind < 14) begin
          cmd = CMD_UNUSED;
        end else if (kind < 22) begin
          // write just outside the addressed matrix
          if ($urandom_range(0, 1) == 1) begin
            cmd = CMD_WRITE_A;
            col = COL_W'($urandom_range(INNER_DIM, 7));
          end else begin
            cmd = CMD_WRITE_B;
            if ($urandom_range(0, 1) == 1) row = ROW_W'($urandom_range(INNER_DIM, 7));
            else col = COL_W'($urandom_range(COLS_B, 7));
          end
        end else if ($urandom_range(0, 1) == 1) begin
          cmd = CMD_WRITE_A;
          row = ROW_W'($urandom_range(0, ROWS_A - 1));
          col = COL_W'($urandom_range(0, INNER_DIM - 1));
        end else begin
          cmd = CMD_WRITE_B;
          row = ROW_W'($urandom_range(0, INNER_DIM - 1));
          col = COL_W'($urandom_range(0, COLS_B - 1));
        end
        // mix extremes, small signed values and full-range values
        sel = $urandom_range(0, 99);
        if (sel < 25) begin
          case ($urandom_range(0, 4))
            0:       val = INT_MIN;
            1:       val = INT_MAX;
            2:       val = ALL_ONES;
            3:       val = '0;
            default: val = 32'd1;
          endcase
        end else if (sel < 60) begin
          val = WORD_W'($urandom_range(0, 200)) - 32'd100;
        end else begin
          val = $urandom;
        end
        send_word(cmd, row, col, val, 1'b0, '0);
        counted++;
      end
      send_word(CMD_COMPUTE, ROW_W'($urandom), COL_W'($urandom), $urandom, 1'b0, '0);
      // pause the sender until every product of this phase is back
      wait_drained();
    end

    idle_phase = PH_FREE;
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (expected_products.size() != 0) begin
      $error("%0d products never arrived", expected_products.size());
      fail_count++;
    end
    $display("Covered %0d computes, %0d element writes and %0d dropped words,",
             computes_taken, writes_taken, drops_taken);
    $display("checking %0d products across four idling phases.", products_checked);
    if (fail_count == 0) begin
      $display("[int_matrix_multiply_unit] OK");
    end else begin
      $display("[int_matrix_multiply_unit] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $error("timeout with %0d products outstanding", expected_products.size());
    $display("[int_matrix_multiply_unit] ERROR");
    $finish;
  end

endmodule
